>>> hw/rtl/base64url_stream_encoder_top_assert.svh
// assertion macros used by the encoder queue rtl
`ifndef BASE64URL_STREAM_ENCODER_TOP_ASSERT_SVH
`define BASE64URL_STREAM_ENCODER_TOP_ASSERT_SVH

// condition must never hold outside reset
`define B64U_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent on the next cycle
`define B64U_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/b64u_pkg.sv
package b64u_pkg;

	// input word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} item_t;

	// result word
	typedef struct packed {
		logic [6:0] code_char;
		logic       last_char;
	} result_t;

	// position inside a three-byte group
	typedef enum logic [1:0] {
		PHASE_0 = 2'd0,
		PHASE_1 = 2'd1,
		PHASE_2 = 2'd2
	} phase_t;

	// one classified byte: one or two sextets to emit
	typedef struct packed {
		logic [5:0] sextet0;
		logic [5:0] sextet1;
		logic       two;
		logic       last;
	} job_t;

	// queue status toward front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam logic [5:0] NUM_UPPER = 6'd26;
	localparam logic [5:0] NUM_ALPHA = 6'd52;
	localparam logic [5:0] NUM_ALNUM = 6'd62;
	localparam logic [5:0] SEXT_DASH = 6'd62;
	localparam logic [6:0] CHAR_UPPER_A = 7'h41;
	localparam logic [6:0] CHAR_LOWER_A = 7'h61;
	localparam logic [6:0] CHAR_ZERO = 7'h30;
	localparam logic [6:0] CHAR_DASH = 7'h2d;
	localparam logic [6:0] CHAR_UNDER = 7'h5f;

	// url-safe alphabet lookup
	function automatic logic [6:0] sextet_to_ascii(input logic [5:0] s);
		logic [6:0] c;
		if (s < NUM_UPPER) begin
			c = CHAR_UPPER_A + {1'b0, s};
		end else if (s < NUM_ALPHA) begin
			c = CHAR_LOWER_A + {1'b0, s - NUM_UPPER};
		end else if (s < NUM_ALNUM) begin
			c = CHAR_ZERO + {1'b0, s - NUM_ALPHA};
		end else if (s == SEXT_DASH) begin
			c = CHAR_DASH;
		end else begin
			c = CHAR_UNDER;
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/base64url_stream_encoder_top.sv
// a byte taken is written to the job queue, then its first character is loaded
// into the output register; one character per cycle leaves that register while
// pop is asserted and the queue holds a job; each byte gives one or two characters
// the job queue between byte splitter and character emitter absorbs stalls
// reset: arst_n low clears phase, queue and output valid at once; no clearing pass
module base64url_stream_encoder_top import b64u_pkg::*; #(
	parameter int QDEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	job_t    front_job;
	job_t    head_job;
	q_stat_t q_stat;
	logic    take;
	logic    deq;

	// accept a word when the queue has room
	assign full = q_stat.full;
	assign take = push && !q_stat.full;

	b64u_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item),
		.job    (front_job)
	);

	b64u_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (take),
		.wr_job (front_job),
		.rd     (deq),
		.rd_job (head_job),
		.stat   (q_stat)
	);

	b64u_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (head_job),
		.stat   (q_stat),
		.deq    (deq),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule

>>> hw/rtl/b64u_queue.sv
`include "base64url_stream_encoder_top_assert.svh"

module b64u_queue import b64u_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  job_t    wr_job,
	input  logic    rd,
	output job_t    rd_job,
	output q_stat_t stat
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slot_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	// status and guarded strobes
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_wr = wr && !stat.full;
	assign do_rd = rd && !stat.empty;
	assign rd_job = slot_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`B64U_ASSERT_NEVER(a_cnt_bound, clk, arst_n, cnt_q > CW'(DEPTH), "queue count over depth")
	`B64U_ASSERT_NEXT(a_cnt_inc, clk, arst_n, do_wr && !do_rd, cnt_q == $past(cnt_q) + 1'b1, "queue count did not rise")
	`B64U_ASSERT_NEXT(a_cnt_dec, clk, arst_n, do_rd && !do_wr, cnt_q == $past(cnt_q) - 1'b1, "queue count did not fall")

endmodule

>>> hw/rtl/b64u_front.sv
module b64u_front import b64u_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  take,
	input  item_t item,
	output job_t  job
);

	phase_t     phase_q;
	logic [3:0] left_q;
	phase_t     phase_d;
	logic [3:0] left_d;

	// split the byte into sextets for the current phase
	always_comb begin
		job     = '0;
		phase_d = PHASE_0;
		left_d  = '0;
		unique case (phase_q)
			PHASE_1: begin
				job.sextet0 = {left_q[1:0], item.data_byte[7:4]};
				if (item.end_of_message) begin
					job.sextet1 = {item.data_byte[3:0], 2'b00};
					job.two     = 1'b1;
					job.last    = 1'b1;
				end else begin
					phase_d = PHASE_2;
					left_d  = item.data_byte[3:0];
				end
			end
			PHASE_2: begin
				job.sextet0 = {left_q, item.data_byte[7:6]};
				job.sextet1 = item.data_byte[5:0];
				job.two     = 1'b1;
				job.last    = item.end_of_message;
			end
			default: begin
				job.sextet0 = item.data_byte[7:2];
				if (item.end_of_message) begin
					job.sextet1 = {item.data_byte[1:0], 4'b0000};
					job.two     = 1'b1;
					job.last    = 1'b1;
				end else begin
					phase_d = PHASE_1;
					left_d  = {2'b00, item.data_byte[1:0]};
				end
			end
		endcase
	end

	// group phase and leftover bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_0;
			left_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

endmodule

>>> hw/rtl/b64u_back.sv
module b64u_back import b64u_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  job_t    job,
	input  q_stat_t stat,
	output logic    deq,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	logic    sel_q;
	logic    out_valid_q;
	result_t out_q;
	logic    load;
	logic    end_of_job;
	logic [5:0] cur_sextet;

	// pick the next character of the head word
	assign load       = !stat.empty && (!out_valid_q || pop);
	assign end_of_job = sel_q || !job.two;
	assign deq        = load && end_of_job;
	assign cur_sextet = sel_q ? job.sextet1 : job.sextet0;

	// output register and character select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sel_q       <= !end_of_job;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// character payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.code_char <= sextet_to_ascii(cur_sextet);
			out_q.last_char <= job.last && end_of_job;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule
